FILE: src/vtc_pkg.sv
`default_nettype none
package vtc_pkg;

	localparam int SPEED_W = 12;
	localparam int RPM_W   = 16;
	localparam int RATE_W  = 16;
	localparam int PCT_W   = 10;
	localparam int O2_W    = 11;
	localparam int MASK_W  = 4;
	localparam int MS_W    = 16;
	localparam int TANK_W  = 11;
	localparam int RED_W   = 14;
	localparam int ACC_W   = 40;
	localparam int GEAR_W  = 4;
	localparam int ACCEL_W = 12;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// shared divider geometry
	localparam int DIV_NUM_W = 50;
	localparam int DIV_DEN_W = 40;
	localparam int DIV_CNT_W = 6;

	// config register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TANK    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_REDLINE = 2'd1;

	// mixture codes
	localparam logic [1:0] MIX_NONE  = 2'd0;
	localparam logic [1:0] MIX_LEAN  = 2'd1;
	localparam logic [1:0] MIX_STOICH = 2'd2;
	localparam logic [1:0] MIX_RICH  = 2'd3;

	// gear ratios in 1e-4 km/h per rpm
	function automatic logic [8:0] gear_ratio(input logic [2:0] g);
		logic [8:0] k;
		case (g)
			3'd1:    k = 9'd52;
			3'd2:    k = 9'd94;
			3'd3:    k = 9'd142;
			3'd4:    k = 9'd195;
			3'd5:    k = 9'd267;
			3'd6:    k = 9'd337;
			default: k = 9'd0;
		endcase
		return k;
	endfunction

	function automatic logic [ACC_W-1:0] acc_sat_add(input logic [ACC_W-1:0] a,
			input logic [31:0] b);
		logic [ACC_W:0] s;
		s = {1'b0, a} + (ACC_W+1)'(b);
		return s[ACC_W] ? {ACC_W{1'b1}} : s[ACC_W-1:0];
	endfunction

endpackage
`default_nettype wire

FILE: src/vtc_if.sv
`default_nettype none
interface vtc_in_if;
	import vtc_pkg::*;
	logic                valid;
	logic                ready;
	logic                cmd;
	logic [SPEED_W-1:0]  vehicle_speed;
	logic [RPM_W-1:0]    engine_speed;
	logic [RATE_W-1:0]   native_fuel_rate;
	logic [RATE_W-1:0]   air_mass_flow;
	logic [PCT_W-1:0]    fuel_level;
	logic [PCT_W-1:0]    calc_load;
	logic [PCT_W-1:0]    throttle_position;
	logic [O2_W-1:0]     oxygen_voltage;
	logic [MASK_W-1:0]   support_mask;
	logic [MS_W-1:0]     elapsed_ms;
	modport source(output valid, cmd, vehicle_speed, engine_speed, native_fuel_rate,
		air_mass_flow, fuel_level, calc_load, throttle_position, oxygen_voltage,
		support_mask, elapsed_ms, input ready);
	modport sink(input valid, cmd, vehicle_speed, engine_speed, native_fuel_rate,
		air_mass_flow, fuel_level, calc_load, throttle_position, oxygen_voltage,
		support_mask, elapsed_ms, output ready);
endinterface

interface vtc_out_if;
	import vtc_pkg::*;
	logic                      valid;
	logic                      ready;
	logic signed [GEAR_W-1:0]  gear;
	logic [15:0]               fuel_rate_out;
	logic [9:0]                instant_economy;
	logic [15:0]               trip_economy;
	logic [15:0]               range_left;
	logic signed [ACCEL_W-1:0] longitudinal_accel;
	logic [9:0]                power_fraction;
	logic                      coasting;
	logic                      idling;
	logic [1:0]                mixture_state;
	logic [3:0]                valid_mask;
	modport source(output valid, gear, fuel_rate_out, instant_economy, trip_economy,
		range_left, longitudinal_accel, power_fraction, coasting, idling,
		mixture_state, valid_mask, input ready);
	modport sink(input valid, gear, fuel_rate_out, instant_economy, trip_economy,
		range_left, longitudinal_accel, power_fraction, coasting, idling,
		mixture_state, valid_mask, output ready);
endinterface

interface vtc_cfg_if;
	import vtc_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: src/vtc_div.sv
`default_nettype none
module vtc_div
	import vtc_pkg::*;
#(
	parameter int NumW = DIV_NUM_W,
	parameter int DenW = DIV_DEN_W,
	parameter int CntW = DIV_CNT_W
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire logic [NumW-1:0] num,    // dividend, left aligned
	input  wire logic [DenW-1:0] den,
	input  wire logic [CntW-1:0] nbits,  // dividend bits to consume
	output logic                 done,
	output logic [NumW-1:0]      quo
);

	logic [NumW-1:0] num_q;
	logic [DenW-1:0] den_q;
	logic [DenW-1:0] rem_q;
	logic [CntW-1:0] cnt_q;
	logic            done_q;
	logic [DenW:0]   trial;
	logic            fits;

	// restoring divide, one quotient bit per cycle
	assign trial = {rem_q, num_q[NumW-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q  <= '0;
			den_q  <= '0;
			rem_q  <= '0;
			cnt_q  <= '0;
			quo    <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				num_q <= num;
				den_q <= den;
				rem_q <= '0;
				quo   <= '0;
				cnt_q <= nbits;
			end else if (cnt_q != '0) begin
				num_q <= {num_q[NumW-2:0], 1'b0};
				rem_q <= fits ? DenW'(trial - {1'b0, den_q}) : trial[DenW-1:0];
				quo   <= {quo[NumW-2:0], fits};
				cnt_q <= cnt_q - CntW'(1);
				if (cnt_q == CntW'(1))
					done_q <= 1'b1;
			end
		end
	end

	assign done = done_q;

endmodule
`default_nettype wire

FILE: src/vehicle_trip_computer_unit.sv
`default_nettype none
// Vehicle trip computer.
// smp: one engine-data sample per beat (cmd 0), or a trip reset (cmd 1).
//   A trip reset clears trip fuel, trip distance and the held trip
//   consumption and produces no result beat.
// res: one result beat per sample: gear, fuel rate, instant/trip
//   consumption, range, longitudinal g, power, flags, mixture, valid mask.
// cfg: register writes (index 0 tank size, 1 redline), always ready;
//   write only while the block is idle.
// Steps: the gear search walks the six ratios through S_GEAR_A and S_GEAR_B
//   (skipped at low speed or low rpm); each divide on the shared restoring
//   divider consumes its bit count (29, 26, 50, 21, 42 and 26 bits; the
//   power divide always runs); the rest are single control states.
// Throughput: one sample at a time; smp.ready is high only when idle, so a
//   new sample waits until the last result is loaded into the output register.
// A finished result sits in an output register; a new sample is taken
//   while it waits, and the next result waits until the receiver takes it.
// Reset: trip state cleared, first-sample flag set, registers to 500/8000.
module vehicle_trip_computer_unit
	import vtc_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	vtc_in_if.sink    smp,
	vtc_out_if.source res,
	vtc_cfg_if.sink   cfg
);

	typedef enum logic [18:0] {
		S_IDLE    = 19'h00001,
		S_GEAR_A  = 19'h00002,
		S_GEAR_B  = 19'h00004,
		S_GEAR_F  = 19'h00008,
		S_FUEL    = 19'h00010,
		S_FUEL_W  = 19'h00020,
		S_MUL     = 19'h00040,
		S_ACC     = 19'h00080,
		S_INST    = 19'h00100,
		S_INST_W  = 19'h00200,
		S_TRIP    = 19'h00400,
		S_TRIP_W  = 19'h00800,
		S_RANGE   = 19'h01000,
		S_RANGE_W = 19'h02000,
		S_ACCEL   = 19'h04000,
		S_ACCEL_W = 19'h08000,
		S_PWR     = 19'h10000,
		S_PWR_W   = 19'h20000,
		S_OUT     = 19'h40000
	} state_t;

	state_t state_q;

	// config
	logic [TANK_W-1:0] tank_q;
	logic [RED_W-1:0]  red_q;

	// captured sample
	logic [SPEED_W-1:0] s_q;
	logic [RPM_W-1:0]   r_q;
	logic [RATE_W-1:0]  fn_q, maf_q;
	logic [PCT_W-1:0]   lvl_q, load_q, thr_q;
	logic [O2_W-1:0]    o2_q;
	logic [MASK_W-1:0]  sup_q;
	logic [MS_W-1:0]    dt_q;

	// trip state
	logic [ACC_W-1:0]   fuel_acc_q, dist_acc_q;
	logic [15:0]        hold_q;
	logic               tvalid_q;
	logic [SPEED_W-1:0] prev_q;
	logic               first_q;
	logic signed [ACCEL_W-1:0] accel_q;

	// per-sample working values
	logic [2:0]  g_q, bg_q;
	logic        gfirst_q;
	logic [26:0] diff_q, bd_q;
	logic [8:0]  bk_q;
	logic signed [GEAR_W-1:0] gear_q;
	logic [15:0] fuel_q;
	logic        fok_q, iok_q, rok_q, neg_q;
	logic [31:0] fprod_q;
	logic [27:0] dprod_q;
	logic [9:0]  inst_q, pwr_q;
	logic [15:0] range_q;

	// output register
	logic        ov_q;
	logic signed [GEAR_W-1:0]  o_gear_q;
	logic [15:0] o_fuel_q, o_trip_q, o_range_q;
	logic [9:0]  o_inst_q, o_pwr_q;
	logic signed [ACCEL_W-1:0] o_accel_q;
	logic        o_coast_q, o_idle_q;
	logic [1:0]  o_mix_q;
	logic [3:0]  o_vmask_q;

	// divider
	logic                 div_start, div_done;
	logic [DIV_NUM_W-1:0] div_num, div_quo;
	logic [DIV_DEN_W-1:0] div_den;
	logic [DIV_CNT_W-1:0] div_nbits;

	// combinational helpers
	logic [8:0]  k_cur;
	logic [26:0] gnum, gden;
	logic [35:0] cmp_l, cmp_r;
	logic [31:0] fin_l, fin_r;
	logic        go_maf, go_inst, go_trip, go_range, go_accel, accel_zero;
	logic [SPEED_W-1:0] ds;
	logic [13:0] red_eff;
	logic [1:0]  mix;
	logic        out_free, out_load;

	assign k_cur = gear_ratio(g_q);
	assign gnum  = 27'(27'(s_q) * 27'd10000);
	assign gden  = 27'(27'({r_q, 2'b00}) * 27'(k_cur));
	assign cmp_l = 36'(diff_q) * 36'(bk_q);
	assign cmp_r = 36'(bd_q) * 36'(k_cur);
	// best error must stay below 30 percent of the ratio
	assign fin_l = 32'(bd_q) * 32'd10;
	assign fin_r = 32'(32'(r_q) * 32'(bk_q) * 32'd12);

	assign go_maf   = !sup_q[0] && sup_q[1];
	assign go_inst  = fok_q && (s_q >= SPEED_W'(80));
	assign go_trip  = (dist_acc_q > ACC_W'(2880000)) && fok_q && (fuel_acc_q != '0);
	assign go_range = sup_q[2] && tvalid_q && (hold_q > 16'd5);
	assign accel_zero = first_q || (dt_q > MS_W'(2000));
	assign go_accel = !accel_zero && (dt_q > MS_W'(1));
	assign ds       = (s_q < prev_q) ? (prev_q - s_q) : (s_q - prev_q);
	assign red_eff  = (red_q == '0) ? 14'd1 : red_q;

	always_comb begin
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		div_nbits = '0;
		unique case (state_q)
			S_FUEL: begin
				div_start = go_maf;
				div_num   = {29'(32'(maf_q) * 32'd7200), 21'b0};
				div_den   = DIV_DEN_W'(108339);
				div_nbits = DIV_CNT_W'(29);
			end
			S_INST: begin
				div_start = go_inst;
				div_num   = {26'(26'(fuel_q) * 26'd800), 24'b0};
				div_den   = DIV_DEN_W'(s_q);
				div_nbits = DIV_CNT_W'(26);
			end
			S_TRIP: begin
				// fuel * 800 as shifted adds
				div_start = go_trip;
				div_num   = (DIV_NUM_W'(fuel_acc_q) << 9) + (DIV_NUM_W'(fuel_acc_q) << 8)
					+ (DIV_NUM_W'(fuel_acc_q) << 5);
				div_den   = dist_acc_q;
				div_nbits = DIV_CNT_W'(50);
			end
			S_RANGE: begin
				div_start = go_range;
				div_num   = {21'(21'(lvl_q) * 21'(tank_q)), 29'b0};
				div_den   = DIV_DEN_W'(20'(20'(hold_q) * 20'd10));
				div_nbits = DIV_CNT_W'(21);
			end
			S_ACCEL: begin
				div_start = go_accel;
				div_num   = {42'(42'(ds) * 42'd1000000000), 8'b0};
				div_den   = DIV_DEN_W'(36'(36'(dt_q) * 36'd565056));
				div_nbits = DIV_CNT_W'(42);
			end
			S_PWR: begin
				div_start = 1'b1;
				div_num   = {26'(26'(load_q) * 26'(r_q)), 24'b0};
				div_den   = DIV_DEN_W'({red_eff, 2'b00});
				div_nbits = DIV_CNT_W'(26);
			end
			default: ;
		endcase
	end

	vtc_div #(
		.NumW(DIV_NUM_W),
		.DenW(DIV_DEN_W),
		.CntW(DIV_CNT_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.nbits (div_nbits),
		.done  (div_done),
		.quo   (div_quo)
	);

	always_comb begin
		if (!sup_q[3])
			mix = MIX_NONE;
		else if (o2_q < O2_W'(350))
			mix = MIX_LEAN;
		else if (o2_q > O2_W'(550))
			mix = MIX_RICH;
		else
			mix = MIX_STOICH;
	end

	// output register takes a new beat once the old one is gone or leaving
	assign out_free = !ov_q || res.ready;
	assign out_load = (state_q == S_OUT) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			tank_q     <= TANK_W'(500);
			red_q      <= RED_W'(8000);
			fuel_acc_q <= '0;
			dist_acc_q <= '0;
			hold_q     <= '0;
			tvalid_q   <= 1'b0;
			prev_q     <= '0;
			first_q    <= 1'b1;
			accel_q    <= '0;
			ov_q       <= 1'b0;
		end else begin
			if (cfg.valid) begin
				unique case (cfg.index)
					CFG_TANK:    tank_q <= cfg.data[TANK_W-1:0];
					CFG_REDLINE: red_q  <= cfg.data[RED_W-1:0];
					default: ;
				endcase
			end
			if (out_load)
				ov_q <= 1'b1;
			else if (res.ready)
				ov_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (smp.valid) begin
						s_q    <= smp.vehicle_speed;
						r_q    <= smp.engine_speed;
						fn_q   <= smp.native_fuel_rate;
						maf_q  <= smp.air_mass_flow;
						lvl_q  <= smp.fuel_level;
						load_q <= smp.calc_load;
						thr_q  <= smp.throttle_position;
						o2_q   <= smp.oxygen_voltage;
						sup_q  <= smp.support_mask;
						dt_q   <= smp.elapsed_ms;
						g_q      <= 3'd1;
						gfirst_q <= 1'b1;
						if (smp.cmd) begin
							fuel_acc_q <= '0;
							dist_acc_q <= '0;
							hold_q     <= '0;
							tvalid_q   <= 1'b0;
						end else begin
							state_q <= S_GEAR_A;
						end
					end
				end
				S_GEAR_A: begin
					if (s_q < SPEED_W'(48) || r_q < RPM_W'(1600)) begin
						gear_q  <= '0;
						state_q <= S_FUEL;
					end else begin
						diff_q  <= (gnum > gden) ? (gnum - gden) : (gden - gnum);
						state_q <= S_GEAR_B;
					end
				end
				S_GEAR_B: begin
					// lowest gear wins a tie
					if (gfirst_q || cmp_l < cmp_r) begin
						bg_q <= g_q;
						bd_q <= diff_q;
						bk_q <= k_cur;
					end
					gfirst_q <= 1'b0;
					if (g_q == 3'd6) begin
						state_q <= S_GEAR_F;
					end else begin
						g_q     <= g_q + 3'd1;
						state_q <= S_GEAR_A;
					end
				end
				S_GEAR_F: begin
					gear_q  <= (fin_l < fin_r) ? signed'({1'b0, bg_q}) : -4'sd1;
					state_q <= S_FUEL;
				end
				S_FUEL: begin
					if (sup_q[0]) begin
						fuel_q  <= fn_q;
						fok_q   <= 1'b1;
						state_q <= S_MUL;
					end else if (sup_q[1]) begin
						fok_q   <= 1'b1;
						state_q <= S_FUEL_W;
					end else begin
						fuel_q  <= '0;
						fok_q   <= 1'b0;
						state_q <= S_MUL;
					end
				end
				S_FUEL_W: begin
					if (div_done) begin
						fuel_q  <= div_quo[15:0];
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					fprod_q <= 32'(fuel_q) * 32'(dt_q);
					dprod_q <= 28'(s_q) * 28'(dt_q);
					state_q <= S_ACC;
				end
				S_ACC: begin
					if (fok_q)
						fuel_acc_q <= acc_sat_add(fuel_acc_q, fprod_q);
					dist_acc_q <= acc_sat_add(dist_acc_q, 32'(dprod_q));
					state_q    <= S_INST;
				end
				S_INST: begin
					if (go_inst) begin
						state_q <= S_INST_W;
					end else begin
						inst_q  <= '0;
						iok_q   <= 1'b0;
						state_q <= S_TRIP;
					end
				end
				S_INST_W: begin
					if (div_done) begin
						inst_q  <= (div_quo > DIV_NUM_W'(999)) ? 10'd999 : div_quo[9:0];
						iok_q   <= 1'b1;
						state_q <= S_TRIP;
					end
				end
				S_TRIP: begin
					state_q <= go_trip ? S_TRIP_W : S_RANGE;
				end
				S_TRIP_W: begin
					if (div_done) begin
						hold_q   <= (|div_quo[DIV_NUM_W-1:16]) ? 16'hFFFF : div_quo[15:0];
						tvalid_q <= 1'b1;
						state_q  <= S_RANGE;
					end
				end
				S_RANGE: begin
					if (go_range) begin
						state_q <= S_RANGE_W;
					end else begin
						range_q <= '0;
						rok_q   <= 1'b0;
						state_q <= S_ACCEL;
					end
				end
				S_RANGE_W: begin
					if (div_done) begin
						range_q <= (|div_quo[DIV_NUM_W-1:16]) ? 16'hFFFF : div_quo[15:0];
						rok_q   <= 1'b1;
						state_q <= S_ACCEL;
					end
				end
				S_ACCEL: begin
					prev_q <= s_q;
					neg_q  <= s_q < prev_q;
					if (accel_zero) begin
						accel_q <= '0;
						first_q <= 1'b0;
						state_q <= S_PWR;
					end else if (go_accel) begin
						state_q <= S_ACCEL_W;
					end else begin
						state_q <= S_PWR;  // short gap: hold last value
					end
				end
				S_ACCEL_W: begin
					if (div_done) begin
						if (div_quo > DIV_NUM_W'(2000))
							accel_q <= neg_q ? -12'sd2000 : 12'sd2000;
						else
							accel_q <= neg_q ? -signed'({1'b0, div_quo[10:0]})
								: signed'({1'b0, div_quo[10:0]});
						state_q <= S_PWR;
					end
				end
				S_PWR: begin
					state_q <= S_PWR_W;
				end
				S_PWR_W: begin
					if (div_done) begin
						pwr_q   <= (div_quo > DIV_NUM_W'(1000)) ? 10'd1000 : div_quo[9:0];
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					// hold here until the output register is free
					if (out_free) begin
						o_gear_q  <= gear_q;
						o_fuel_q  <= fuel_q;
						o_inst_q  <= inst_q;
						o_trip_q  <= tvalid_q ? hold_q : 16'd0;
						o_range_q <= range_q;
						o_accel_q <= accel_q;
						o_pwr_q   <= pwr_q;
						o_coast_q <= (thr_q < PCT_W'(20)) && (s_q > SPEED_W'(160))
							&& (r_q > RPM_W'(3200));
						o_idle_q  <= (r_q > RPM_W'(1600)) && (r_q < RPM_W'(4400))
							&& (s_q < SPEED_W'(48));
						o_mix_q   <= mix;
						o_vmask_q <= {rok_q, tvalid_q, iok_q, fok_q};
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign smp.ready = state_q == S_IDLE;
	assign cfg.ready = 1'b1;

	assign res.valid              = ov_q;
	assign res.gear               = o_gear_q;
	assign res.fuel_rate_out      = o_fuel_q;
	assign res.instant_economy    = o_inst_q;
	assign res.trip_economy       = o_trip_q;
	assign res.range_left         = o_range_q;
	assign res.longitudinal_accel = o_accel_q;
	assign res.power_fraction     = o_pwr_q;
	assign res.coasting           = o_coast_q;
	assign res.idling             = o_idle_q;
	assign res.mixture_state      = o_mix_q;
	assign res.valid_mask         = o_vmask_q;

endmodule
`default_nettype wire
